FILE: design/strt_pkg.sv
// ----------------------------------------------------------------------------
// STUN retransmit timer package
// Shared widths, codes and transfer payload types for the retransmit timer.
// ----------------------------------------------------------------------------
`default_nettype none

package strt_pkg;

  // Widths of time, timeout, count and multiplier values.
  localparam int TIME_W = 32;
  localparam int RTO_W  = 24;
  localparam int CNT_W  = 8;
  localparam int MULT_W = 8;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Item kinds carried on the input channel.
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_POLL  = 2'd1,
    MODE_SERR  = 2'd2
  } mode_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_WAIT    = 3'd1,
    ST_RTX     = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_RESCHED = 3'd4,
    ST_FAILED  = 3'd5
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REQUEST_COUNT      = 3'd0,
    CFG_RTO_MULTIPLIER     = 3'd1,
    CFG_MAX_RTO_ENABLE     = 3'd2,
    CFG_MAX_RTO            = 3'd3,
    CFG_SERR_ENABLE        = 3'd4,
    CFG_SERR_TIMEOUT       = 3'd5,
    CFG_SERR_MAX_RETRIES   = 3'd6
  } cfg_reg_t;

  // Input item.
  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] now;
    logic [RTO_W-1:0]  first_rto;
  } in_item_t;

  // Result item.
  typedef struct packed {
    status_t           status;
    logic [TIME_W-1:0] deadline;
    logic [RTO_W-1:0]  applied_rto;
    logic [CNT_W-1:0]  retransmits;
  } out_item_t;

endpackage

`default_nettype wire

FILE: design/stun_retransmit_timer.sv
// ----------------------------------------------------------------------------
// STUN retransmit timer
// Retransmission timer for one STUN request transaction with backoff,
// request budget, timeout cap and server error retries.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless the result side stalls; the update
//   from input register to result register and timer state is a single pass
//   through the backoff logic.
// Reset: synchronous, active low; clears both registers' valid flags, the
//   timer state and restores the configuration registers to their defaults.
`default_nettype none

module stun_retransmit_timer (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire strt_pkg::in_item_t                  in_data,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output strt_pkg::out_item_t                      out_data,
  // Configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [strt_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [strt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import strt_pkg::*;

  localparam int PROD_W = RTO_W + MULT_W;
  localparam int BUD_W  = CNT_W + 2;

  // Configuration registers
  logic [CNT_W-1:0]  request_count_r;
  logic [MULT_W-1:0] rto_multiplier_r;
  logic              max_rto_enable_r;
  logic [RTO_W-1:0]  max_rto_r;
  logic              serr_enable_r;
  logic [RTO_W-1:0]  serr_timeout_r;
  logic [CNT_W-1:0]  serr_max_retries_r;

  // Input register and result register
  logic      in_valid_r;
  in_item_t  in_r;
  logic      out_valid_r;
  out_item_t out_r;
  out_item_t out_nxt;

  // Timer state
  logic              armed_r,      armed_nxt;
  logic [TIME_W-1:0] due_time_r,   due_time_nxt;
  logic [RTO_W-1:0]  cur_rto_r,    cur_rto_nxt;
  logic [RTO_W-1:0]  start_rto_r,  start_rto_nxt;
  logic [CNT_W-1:0]  rtx_count_r,  rtx_count_nxt;
  logic [CNT_W-1:0]  serr_count_r, serr_count_nxt;

  // Datapath terms
  logic              advance;
  logic [TIME_W-1:0] time_diff;
  logic              time_reached;
  logic              budget_spent;
  logic              last_request;
  logic [PROD_W-1:0] mult_prod;
  logic [RTO_W-1:0]  mult_rto;
  logic [RTO_W:0]    dbl_prod;
  logic [RTO_W-1:0]  dbl_rto;
  logic [RTO_W-1:0]  backoff_rto;
  logic [RTO_W-1:0]  capped_rto;

  // Handshake: the input register moves whenever the result register is
  // free or being emptied in this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      request_count_r    <= CNT_W'(7);
      rto_multiplier_r   <= MULT_W'(16);
      max_rto_enable_r   <= 1'b0;
      max_rto_r          <= '0;
      serr_enable_r      <= 1'b0;
      serr_timeout_r     <= '0;
      serr_max_retries_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_REQUEST_COUNT:    request_count_r    <= cfg_data[CNT_W-1:0];
        CFG_RTO_MULTIPLIER:   rto_multiplier_r   <= cfg_data[MULT_W-1:0];
        CFG_MAX_RTO_ENABLE:   max_rto_enable_r   <= cfg_data[0];
        CFG_MAX_RTO:          max_rto_r          <= cfg_data[RTO_W-1:0];
        CFG_SERR_ENABLE:      serr_enable_r      <= cfg_data[0];
        CFG_SERR_TIMEOUT:     serr_timeout_r     <= cfg_data[RTO_W-1:0];
        CFG_SERR_MAX_RETRIES: serr_max_retries_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: captures each transfer on the input channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Deadline compare by wrapping signed difference.
  assign time_diff    = in_r.now - due_time_r;
  assign time_reached = !time_diff[TIME_W-1];

  // Request budget: each server error retry adds one request.
  assign budget_spent = ({2'b00, rtx_count_r} + BUD_W'(1)) >=
                        ({2'b00, request_count_r} + {2'b00, serr_count_r});
  assign last_request = ({1'b0, rtx_count_r} + (CNT_W+1)'(2)) == {1'b0, request_count_r};

  // Backoff candidates, saturated at the timeout width.
  assign mult_prod = PROD_W'(start_rto_r) * PROD_W'(rto_multiplier_r);
  assign mult_rto  = (|mult_prod[PROD_W-1:RTO_W]) ? '1 : mult_prod[RTO_W-1:0];
  assign dbl_prod  = {cur_rto_r, 1'b0};
  assign dbl_rto   = dbl_prod[RTO_W] ? '1 : dbl_prod[RTO_W-1:0];

  assign backoff_rto = last_request ? mult_rto : dbl_rto;
  assign capped_rto  = (max_rto_enable_r && (backoff_rto > max_rto_r)) ? max_rto_r
                                                                       : backoff_rto;

  // Item processing: next timer state and result.
  always_comb begin
    armed_nxt      = armed_r;
    due_time_nxt   = due_time_r;
    cur_rto_nxt    = cur_rto_r;
    start_rto_nxt  = start_rto_r;
    rtx_count_nxt  = rtx_count_r;
    serr_count_nxt = serr_count_r;
    out_nxt.status = armed_r ? ST_WAIT : ST_IDLE;

    case (in_r.mode)
      MODE_START: begin
        start_rto_nxt  = in_r.first_rto;
        cur_rto_nxt    = in_r.first_rto;
        due_time_nxt   = in_r.now + TIME_W'(in_r.first_rto);
        rtx_count_nxt  = '0;
        serr_count_nxt = '0;
        armed_nxt      = 1'b1;
        out_nxt.status = ST_WAIT;
      end
      MODE_POLL: begin
        if (!armed_r) begin
          out_nxt.status = ST_IDLE;
        end else if (!time_reached) begin
          out_nxt.status = ST_WAIT;
        end else if (budget_spent) begin
          armed_nxt      = 1'b0;
          out_nxt.status = ST_TIMEOUT;
        end else begin
          cur_rto_nxt    = capped_rto;
          due_time_nxt   = in_r.now + TIME_W'(capped_rto);
          rtx_count_nxt  = (&rtx_count_r) ? rtx_count_r : rtx_count_r + CNT_W'(1);
          out_nxt.status = ST_RTX;
        end
      end
      MODE_SERR: begin
        if (!armed_r) begin
          out_nxt.status = ST_IDLE;
        end else if (!serr_enable_r || (serr_count_r >= serr_max_retries_r)) begin
          armed_nxt      = 1'b0;
          out_nxt.status = ST_FAILED;
        end else begin
          serr_count_nxt = (&serr_count_r) ? serr_count_r : serr_count_r + CNT_W'(1);
          due_time_nxt   = in_r.now + TIME_W'(serr_timeout_r);
          out_nxt.status = ST_RESCHED;
        end
      end
      default: ;
    endcase

    out_nxt.deadline    = armed_nxt ? due_time_nxt : '0;
    out_nxt.applied_rto = cur_rto_nxt;
    out_nxt.retransmits = rtx_count_nxt;
  end

  // Timer state update on each processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r      <= 1'b0;
      due_time_r   <= '0;
      cur_rto_r    <= '0;
      start_rto_r  <= '0;
      rtx_count_r  <= '0;
      serr_count_r <= '0;
    end else if (advance) begin
      armed_r      <= armed_nxt;
      due_time_r   <= due_time_nxt;
      cur_rto_r    <= cur_rto_nxt;
      start_rto_r  <= start_rto_nxt;
      rtx_count_r  <= rtx_count_nxt;
      serr_count_r <= serr_count_nxt;
    end
  end

  // Result register: loads on processing, empties on an output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  // The timer can only become armed through a processed start item.
  a_arm_only_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (!armed_r && !(advance && (in_r.mode == MODE_START))) |=> !armed_r)
    else $error("timer armed without a start item");

  // A held input item is never lost while the result side stalls.
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("input register dropped an unprocessed item");

  // A terminal result always reports a cleared deadline.
  a_terminal_no_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_r.status == ST_TIMEOUT) || (out_r.status == ST_FAILED)))
      |-> (out_r.deadline == '0))
    else $error("terminal status with a nonzero deadline");

  // A retransmit result always carries a nonzero retransmit count.
  a_rtx_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status == ST_RTX)) |-> (out_r.retransmits != '0))
    else $error("retransmit reported without counting it");

endmodule

`default_nettype wire
